// File: design/rsa_me_pkg.sv
// ----------------------------------------------------------------------------
// rsa_me_pkg
// Shared widths, register indexes, reset values and inter-module structs for
// the modular exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

package rsa_me_pkg;

   // datapath width, also the width of value, modulus and exponent
   localparam int WORD_BITS      = 32;
   localparam int CNT_BITS       = $clog2(WORD_BITS);
   localparam int CSR_INDEX_BITS = 2;

   typedef logic [WORD_BITS-1:0] word_type;

   // register indexes on the configuration port
   localparam logic [CSR_INDEX_BITS-1:0] REG_MODULUS  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_EXPONENT = CSR_INDEX_BITS'(1);

   localparam word_type MODULUS_RESET  = WORD_BITS'(3233);
   localparam word_type EXPONENT_RESET = WORD_BITS'(17);
   localparam word_type WORD_ZERO      = WORD_BITS'(0);
   localparam word_type WORD_ONE       = WORD_BITS'(1);

   // request to the shared modular multiplier
   typedef struct packed {
      logic     start;
      word_type a;
      word_type b;
   } mul_req_type;

   // answer from the shared modular multiplier
   typedef struct packed {
      logic     done;
      word_type prod;
   } mul_rsp_type;

   // finished result from the sequencer
   typedef struct packed {
      logic     valid;
      word_type value;
   } result_type;

endpackage

`default_nettype wire

// File: design/rsa_me_modmul.sv
// ----------------------------------------------------------------------------
// rsa_me_modmul
// Bit-serial interleaved modular multiplier: (a * b) mod m, one bit of a per
// cycle, most significant first. Needs b < m, or b equal to one.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_me_modmul (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rsa_me_pkg::mul_req_type req,
   input  wire rsa_me_pkg::word_type    modulus,
   output rsa_me_pkg::mul_rsp_type      rsp
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [rsa_me_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   rsa_me_pkg::word_type            a_ff, a_in;
   rsa_me_pkg::word_type            b_ff, b_in;
   rsa_me_pkg::word_type            acc_ff, acc_in;

   logic [rsa_me_pkg::WORD_BITS:0]  m_ext;
   logic [rsa_me_pkg::WORD_BITS:0]  dbl, red1, sum, red2;

   // one step: double and reduce, add b when the bit is set and reduce again
   always_comb begin
      m_ext = {1'b0, modulus};
      dbl   = {acc_ff, 1'b0};
      red1  = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
      sum   = red1 + (a_ff[rsa_me_pkg::WORD_BITS-1] ? {1'b0, b_ff}
                                                    : {(rsa_me_pkg::WORD_BITS+1){1'b0}});
      red2  = (sum >= m_ext) ? (sum - m_ext) : sum;
   end

   // load operands on start, then step until the last bit of a
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (req.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = rsa_me_pkg::CNT_BITS'(rsa_me_pkg::WORD_BITS - 1);
         a_in    = req.a;
         b_in    = req.b;
         acc_in  = rsa_me_pkg::WORD_ZERO;
      end else if (busy_ff) begin
         acc_in = red2[rsa_me_pkg::WORD_BITS-1:0];
         a_in   = {a_ff[rsa_me_pkg::WORD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;

endmodule

`default_nettype wire

// File: design/rsa_me_seq.sv
// ----------------------------------------------------------------------------
// rsa_me_seq
// Square-and-multiply sequencer: scans the exponent from its least
// significant bit and drives the shared modular multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_me_seq (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire rsa_me_pkg::word_type    value,
   input  wire rsa_me_pkg::word_type    modulus,
   input  wire rsa_me_pkg::word_type    exponent,
   input  wire logic                    taken,
   output logic                         idle,
   output rsa_me_pkg::result_type       res,
   output rsa_me_pkg::mul_req_type      mul_req,
   input  wire rsa_me_pkg::mul_rsp_type mul_rsp,
   output rsa_me_pkg::word_type         mul_modulus
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REDUCE = 5'b00010,
      ST_MUL    = 5'b00100,
      ST_SQR    = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   rsa_me_pkg::word_type ex_ff, ex_in;
   rsa_me_pkg::word_type m_ff, m_in;
   rsa_me_pkg::word_type base_ff, base_in;
   rsa_me_pkg::word_type acc_ff, acc_in;
   rsa_me_pkg::word_type ex_sh;

   assign ex_sh = {1'b0, ex_ff[rsa_me_pkg::WORD_BITS-1:1]};

   // next state and multiplier requests
   always_comb begin
      state_in      = state_ff;
      ex_in         = ex_ff;
      m_in          = m_ff;
      base_in       = base_ff;
      acc_in        = acc_ff;
      mul_req.start = 1'b0;
      mul_req.a     = acc_ff;
      mul_req.b     = base_ff;
      unique case (state_ff) inside
         ST_IDLE: begin
            if (start) begin
               m_in  = modulus;
               ex_in = exponent;
               if (modulus == rsa_me_pkg::WORD_ZERO) begin
                  acc_in   = rsa_me_pkg::WORD_ZERO;
                  state_in = ST_FINISH;
               end else if (exponent == rsa_me_pkg::WORD_ZERO) begin
                  acc_in   = rsa_me_pkg::WORD_ONE;
                  state_in = ST_FINISH;
               end else begin
                  // reduce the value as value * 1 mod m
                  acc_in        = rsa_me_pkg::WORD_ONE;
                  mul_req.start = 1'b1;
                  mul_req.a     = value;
                  mul_req.b     = rsa_me_pkg::WORD_ONE;
                  state_in      = ST_REDUCE;
               end
            end
         end
         ST_REDUCE, ST_SQR: begin
            if (mul_rsp.done) begin
               base_in = mul_rsp.prod;
               if (ex_ff[0]) begin
                  mul_req.start = 1'b1;
                  mul_req.a     = acc_ff;
                  mul_req.b     = mul_rsp.prod;
                  state_in      = ST_MUL;
               end else begin
                  // clear bit: drop it and square the base straight away
                  ex_in         = ex_sh;
                  mul_req.start = 1'b1;
                  mul_req.a     = mul_rsp.prod;
                  mul_req.b     = mul_rsp.prod;
                  state_in      = ST_SQR;
               end
            end
         end
         ST_MUL: begin
            if (mul_rsp.done) begin
               acc_in = mul_rsp.prod;
               ex_in  = ex_sh;
               if (ex_sh == rsa_me_pkg::WORD_ZERO) begin
                  state_in = ST_FINISH;
               end else begin
                  mul_req.start = 1'b1;
                  mul_req.a     = base_ff;
                  mul_req.b     = base_ff;
                  state_in      = ST_SQR;
               end
            end
         end
         ST_FINISH: begin
            // hold the result until the output register takes it
            if (taken) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ex_ff   <= ex_in;
      m_ff    <= m_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
   end

   assign idle        = (state_ff == ST_IDLE);
   assign res.valid   = (state_ff == ST_FINISH);
   assign res.value   = acc_ff;
   assign mul_modulus = m_ff;

endmodule

`default_nettype wire

// File: design/rsa_modular_exponentiation.sv
// ----------------------------------------------------------------------------
// rsa_modular_exponentiation
// Each modular multiplication steps bit-serially over a, then hands over; an
// item needs one to reduce the value, one per set exponent bit and one square
// per bit below the top set bit, so at most 64 multiplications.
// One item at a time: a new value is taken only when the sequencer is idle;
// a zero modulus or exponent skips the multiplier.
// Reset: synchronous; modulus returns to 3233 and exponent to 17.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_modular_exponentiation (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [rsa_me_pkg::WORD_BITS-1:0]      req_value_in,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [rsa_me_pkg::WORD_BITS-1:0]           rsp_value_out,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [rsa_me_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [rsa_me_pkg::WORD_BITS-1:0]      csr_wdata
);

   rsa_me_pkg::word_type    modulus_ff, modulus_in;
   rsa_me_pkg::word_type    exponent_ff, exponent_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsa_me_pkg::word_type    rsp_value_ff, rsp_value_in;

   logic                    seq_idle;
   logic                    taken;
   rsa_me_pkg::result_type  res;
   rsa_me_pkg::mul_req_type mul_req;
   rsa_me_pkg::mul_rsp_type mul_rsp;
   rsa_me_pkg::word_type    mul_modulus;

   assign csr_ready = 1'b1;
   assign req_ready = seq_idle;

   // register writes; indexes beyond the list are dropped
   always_comb begin
      modulus_in  = modulus_ff;
      exponent_in = exponent_ff;
      if (csr_valid) begin
         case (csr_index)
            rsa_me_pkg::REG_MODULUS:  modulus_in  = csr_wdata;
            rsa_me_pkg::REG_EXPONENT: exponent_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // output register: take a result when empty or emptied in this transfer
   always_comb begin
      taken        = res.valid && (!rsp_valid_ff || rsp_ready);
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (taken) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = res.value;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= rsa_me_pkg::MODULUS_RESET;
         exponent_ff  <= rsa_me_pkg::EXPONENT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         exponent_ff  <= exponent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;

   rsa_me_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (req_valid && seq_idle),
      .value       (req_value_in),
      .modulus     (modulus_ff),
      .exponent    (exponent_ff),
      .taken       (taken),
      .idle        (seq_idle),
      .res         (res),
      .mul_req     (mul_req),
      .mul_rsp     (mul_rsp),
      .mul_modulus (mul_modulus)
   );

   rsa_me_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .req     (mul_req),
      .modulus (mul_modulus),
      .rsp     (mul_rsp)
   );

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for rsa_modular_exponentiation. A scoreboard class keeps
// its own copy of modulus and exponent and works out each power by
// square-and-multiply on 64-bit products. Directed items cover the register
// extremes, the zero exponent, and the moduli of one and zero. Random phases
// then follow, with random idling on both sides and one long result hold-off.
// ----------------------------------------------------------------------------

module tb_top;
   import rsa_me_pkg::*;

   localparam int unsigned MAX_GAP          = 13;
   localparam int unsigned LONG_HOLD_CYCLES = 400;
   localparam int unsigned SETTLE_CYCLES    = 4;
   // long enough for the worst item, from transfer to result
   localparam int unsigned TAIL_CYCLES      = 2200;
   // several worst items plus the long hold-off, with no transfer at all
   localparam int unsigned WATCHDOG_LIMIT   = 20000;
   localparam int unsigned RANDOM_PHASES    = 13;
   localparam int unsigned PHASE_ITEMS      = 20;

   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_LO = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_HI = CSR_INDEX_BITS'(3);
   localparam word_type WORD_ALL_ONES = '1;

   // expected powers, in the order their values were accepted
   class power_ledger;
      word_type    modulus_reg;
      word_type    exponent_reg;
      word_type    pending_powers[$];
      int unsigned mismatch_count;

      function new();
         modulus_reg    = MODULUS_RESET;
         exponent_reg   = EXPONENT_RESET;
         mismatch_count = 0;
      endfunction

      function void set_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input word_type data);
         case (index)
            REG_MODULUS:  modulus_reg  = data;
            REG_EXPONENT: exponent_reg = data;
            default:      ;
         endcase
      endfunction

      // scan the exponent from its low bit; multiply on set bits, square always
      function word_type power_of(input word_type value);
         logic [63:0] base;
         logic [63:0] acc;
         logic [63:0] divisor;
         word_type    bits;
         if (modulus_reg == WORD_ZERO)
            return WORD_ZERO;
         if (exponent_reg == WORD_ZERO)
            return WORD_ONE;
         divisor = 64'(modulus_reg);
         base    = 64'(value) % divisor;
         acc     = 64'd1;
         bits    = exponent_reg;
         while (bits != WORD_ZERO) begin
            if (bits[0])
               acc = (acc * base) % divisor;
            base = (base * base) % divisor;
            bits = bits >> 1;
         end
         return word_type'(acc);
      endfunction

      function void note_request(input word_type value);
         pending_powers = {pending_powers, power_of(value)};
      endfunction

      function void check_response(input word_type actual);
         word_type wanted;
         if (pending_powers.size() == 0) begin
            $display("%0t: value_out with none pending: expected nothing, got %h",
                     $time, actual);
            mismatch_count++;
         end else begin
            wanted = pending_powers.pop_front();
            if (actual !== wanted) begin
               $display("%0t: value_out mismatch: expected %h, got %h",
                        $time, wanted, actual);
               mismatch_count++;
            end
         end
      endfunction

      function int unsigned outstanding();
         return pending_powers.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   word_type                  req_value_in;
   logic                      rsp_valid;
   logic                      rsp_ready;
   word_type                  rsp_value_out;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   word_type                  csr_wdata;

   power_ledger ledger = new();
   bit          sender_eager;
   bit          long_hold_due;

   rsa_modular_exponentiation u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_out (rsp_value_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned draw_gap(input bit eager);
      return eager ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic word_type pick_value(input word_type m);
      case ($urandom_range(0, 7))
         0:       return WORD_ZERO;
         1:       return WORD_ALL_ONES;
         2:       return m - WORD_ONE;
         3:       return m + WORD_ONE;
         default: return $urandom();
      endcase
   endfunction

   function automatic word_type pick_modulus();
      case ($urandom_range(0, 7))
         0:       return WORD_ONE;
         1:       return word_type'(2);
         2:       return WORD_ALL_ONES;
         3:       return word_type'($urandom_range(3, 255));
         4:       return WORD_ZERO;
         default: return $urandom();
      endcase
   endfunction

   function automatic word_type pick_exponent();
      case ($urandom_range(0, 7)) inside
         0:       return WORD_ZERO;
         1:       return WORD_ALL_ONES;
         2:       return WORD_ONE;
         3, 4:    return $urandom();
         default: return word_type'($urandom_range(2, 1023));
      endcase
   endfunction

   // offer one value after a random gap, hold it until the transfer
   task automatic send_value(input word_type value);
      int unsigned gap;
      gap = draw_gap(sender_eager);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_value_in <= value;
      do @(posedge clock); while (!(req_valid && req_ready));
      ledger.note_request(value);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index, input word_type data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      ledger.set_register(index, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering and wait until every expected power has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (ledger.outstanding() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input word_type m, input word_type e);
      drain();
      write_reg(REG_MODULUS, m);
      write_reg(REG_EXPONENT, e);
   endtask

   // result side: random stalls counted from valid, one long hold-off on request
   initial begin : result_sink
      int unsigned stall;
      int unsigned taken;
      bit          eager;
      rsp_ready <= 1'b0;
      taken = 0;
      eager = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken % 16 == 0)
            eager = ($urandom_range(0, 2) == 0);
         stall = draw_gap(eager);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (stall > 0) begin
            rsp_ready <= 1'b0;
            do @(posedge clock); while (!rsp_valid);
            repeat (stall - 1) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         ledger.check_response(rsp_value_out);
         taken++;
      end
   end

   // end the run when no channel has moved for too long
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      word_type m;
      word_type e;
      req_valid     <= 1'b0;
      req_value_in  <= WORD_ZERO;
      csr_valid     <= 1'b0;
      csr_index     <= REG_MODULUS;
      csr_wdata     <= WORD_ZERO;
      reset         <= 1'b1;
      sender_eager  = 1'b0;
      long_hold_due = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: values below, at and above the modulus
      send_value(WORD_ZERO);
      send_value(WORD_ONE);
      send_value(word_type'(65));
      send_value(WORD_ALL_ONES);
      send_value(word_type'(3232));
      send_value(MODULUS_RESET);
      send_value(word_type'(3234));

      // widest modulus and exponent: full scan of all exponent bits
      configure(WORD_ALL_ONES, WORD_ALL_ONES);
      send_value(WORD_ZERO);
      send_value(WORD_ALL_ONES);
      send_value(WORD_ALL_ONES - WORD_ONE);
      send_value(32'h8000_0001);

      // zero exponent gives one
      configure(word_type'(7), WORD_ZERO);
      send_value(WORD_ZERO);
      send_value(word_type'(5));
      send_value(WORD_ALL_ONES);

      // modulus of one with a nonzero exponent gives zero
      configure(WORD_ONE, word_type'(5));
      send_value(WORD_ZERO);
      send_value(word_type'(9));

      // zero modulus gives zero, also with a zero exponent
      configure(WORD_ZERO, word_type'(3));
      send_value(word_type'(7));
      send_value(WORD_ALL_ONES);
      configure(WORD_ZERO, WORD_ZERO);
      send_value(word_type'(4));

      // writes to spare indexes must leave both registers alone
      configure(WORD_ONE, WORD_ZERO);
      write_reg(REG_SPARE_LO, WORD_ALL_ONES);
      write_reg(REG_SPARE_HI, 32'h5555_aaaa);
      send_value(word_type'(3));

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            // short exponent, eager sender, long result hold-off: fill the block
            m = $urandom() | 32'h8000_0000;
            e = word_type'(3);
            sender_eager = 1'b1;
            configure(m, e);
            long_hold_due = 1'b1;
         end else begin
            m = pick_modulus();
            e = pick_exponent();
            sender_eager = ($urandom_range(0, 2) == 0);
            configure(m, e);
            if ($urandom_range(0, 3) == 0)
               write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
         end
         repeat (PHASE_ITEMS) send_value(pick_value(m));
      end

      // drain, then watch for stray results
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (ledger.mismatch_count == 0 && ledger.outstanding() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: files.f
design/rsa_me_pkg.sv
design/rsa_me_modmul.sv
design/rsa_me_seq.sv
design/rsa_modular_exponentiation.sv
tb/sv/tb_top.sv
